// ----- rtl/core/lbs_pkg.sv -----
package lbs_pkg;

    localparam int unsigned LevelWidth = 8;
    localparam int unsigned PhaseWidth = 2;
    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth = 8;

    localparam logic [LevelWidth-1:0] LevelTop = 8'd255;
    localparam logic [LevelWidth-1:0] HoldReset = 8'd60;

    localparam logic [CfgIndexWidth-1:0] RegGreenLevel = 3'd0;
    localparam logic [CfgIndexWidth-1:0] RegRedLevel = 3'd1;
    localparam logic [CfgIndexWidth-1:0] RegBlueLevel = 3'd2;
    localparam logic [CfgIndexWidth-1:0] RegHoldTicks = 3'd3;

    localparam logic [PhaseWidth-1:0] PhaseCodeFall = 2'd0;
    localparam logic [PhaseWidth-1:0] PhaseCodeHold = 2'd1;
    localparam logic [PhaseWidth-1:0] PhaseCodeRise = 2'd2;

    typedef enum logic [2:0] {
        PH_FALL = 3'b001,
        PH_HOLD = 3'b010,
        PH_RISE = 3'b100
    } phase_t;

    typedef struct packed {
        logic [LevelWidth-1:0] level;
        logic [PhaseWidth-1:0] phase_code;
    } step_result_t;

    typedef struct packed {
        logic [LevelWidth-1:0] green;
        logic [LevelWidth-1:0] red;
        logic [LevelWidth-1:0] blue;
    } peaks_t;

    function automatic logic [PhaseWidth-1:0] phase_code(input phase_t ph);
        logic [PhaseWidth-1:0] code;
        case (ph)
            PH_FALL: code = PhaseCodeFall;
            PH_HOLD: code = PhaseCodeHold;
            PH_RISE: code = PhaseCodeRise;
            default: code = PhaseCodeFall;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/core/lbs_sequencer.sv -----
module lbs_sequencer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [lbs_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [lbs_pkg::CfgDataWidth-1:0]     cfg_data,
    input  logic                                 step_accept,
    input  logic                                 advance,
    output lbs_pkg::peaks_t                      peaks,
    output lbs_pkg::step_result_t                step_result
);

    logic [lbs_pkg::LevelWidth-1:0] green_level_reg;
    logic [lbs_pkg::LevelWidth-1:0] red_level_reg;
    logic [lbs_pkg::LevelWidth-1:0] blue_level_reg;
    logic [lbs_pkg::LevelWidth-1:0] hold_ticks_reg;

    logic [lbs_pkg::LevelWidth-1:0] level_count_reg;
    logic [lbs_pkg::LevelWidth-1:0] level_count_next;
    logic [lbs_pkg::LevelWidth-1:0] hold_count_reg;
    logic [lbs_pkg::LevelWidth-1:0] hold_count_next;
    lbs_pkg::phase_t                phase_reg;
    lbs_pkg::phase_t                phase_next;

    logic [lbs_pkg::LevelWidth-1:0] level_tick;
    logic [lbs_pkg::LevelWidth-1:0] hold_tick;
    lbs_pkg::phase_t                phase_tick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            green_level_reg <= '0;
            red_level_reg   <= '0;
            blue_level_reg  <= '0;
            hold_ticks_reg  <= lbs_pkg::HoldReset;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lbs_pkg::RegGreenLevel: green_level_reg <= cfg_data;
                lbs_pkg::RegRedLevel:   red_level_reg   <= cfg_data;
                lbs_pkg::RegBlueLevel:  blue_level_reg  <= cfg_data;
                lbs_pkg::RegHoldTicks:  hold_ticks_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        level_tick = level_count_reg;
        hold_tick  = hold_count_reg;
        phase_tick = phase_reg;
        case (phase_reg)
            lbs_pkg::PH_FALL:
            begin
                if (level_count_reg != '0)
                    level_tick = level_count_reg - 8'd1;
                else
                    phase_tick = lbs_pkg::PH_HOLD;
            end
            lbs_pkg::PH_HOLD:
            begin
                if (hold_count_reg < hold_ticks_reg)
                    hold_tick = hold_count_reg + 8'd1;
                else
                begin
                    phase_tick = lbs_pkg::PH_RISE;
                    hold_tick  = '0;
                end
            end
            default:
            begin
                if (level_count_reg < lbs_pkg::LevelTop)
                    level_tick = level_count_reg + 8'd1;
                else
                    phase_tick = lbs_pkg::PH_FALL;
            end
        endcase
    end

    always_comb
    begin
        if (advance)
        begin
            level_count_next = level_tick;
            hold_count_next  = hold_tick;
            phase_next       = phase_tick;
        end
        else
        begin
            level_count_next = level_count_reg;
            hold_count_next  = hold_count_reg;
            phase_next       = phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg <= lbs_pkg::LevelTop;
            hold_count_reg  <= '0;
            phase_reg       <= lbs_pkg::PH_FALL;
        end
        else if (step_accept)
        begin
            level_count_reg <= level_count_next;
            hold_count_reg  <= hold_count_next;
            phase_reg       <= phase_next;
        end
    end

    assign peaks.green = green_level_reg;
    assign peaks.red   = red_level_reg;
    assign peaks.blue  = blue_level_reg;

    assign step_result.level      = level_count_next;
    assign step_result.phase_code = lbs_pkg::phase_code(phase_next);

endmodule

// ----- rtl/core/lbs_scaler.sv -----
module lbs_scaler (
    input  logic [lbs_pkg::LevelWidth-1:0] level,
    input  lbs_pkg::peaks_t                peaks,
    output lbs_pkg::peaks_t                scaled
);

    function automatic logic [lbs_pkg::LevelWidth-1:0] scale(
        input logic [lbs_pkg::LevelWidth-1:0] lvl,
        input logic [lbs_pkg::LevelWidth-1:0] peak
    );
        logic [2*lbs_pkg::LevelWidth-1:0] prod;
        logic [2*lbs_pkg::LevelWidth:0]   sum;
        prod = lvl * peak;
        // floor(prod / 255) for any product of two 8-bit values
        sum = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
        return sum[15:8];
    endfunction

    assign scaled.green = scale(level, peaks.green);
    assign scaled.red   = scale(level, peaks.red);
    assign scaled.blue  = scale(level, peaks.blue);

endmodule

// ----- rtl/core/led_breathing_sequencer.sv -----
// Breathing-light sequencer for one RGB color. Each accepted request with
// advance high steps a level counter one tick: falling from 255 to 0, dark
// for hold_ticks + 1 ticks, rising back to 255, then falling again; with
// advance low it only reports. Every request returns one result with each
// channel scaled to floor(level * peak / 255) and the phase (0 falling,
// 1 holding, 2 rising). One request is taken per cycle while in_stall is low;
// the result is registered in the output register, or first in the skid entry
// when the output register holds a result under out_stall, and this two-entry
// output buffer keeps input acceptance going while one result waits under
// out_stall. Registers 0..3 are green, red, blue peak and hold_ticks; write them only while the block is idle.
module led_breathing_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [lbs_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [lbs_pkg::CfgDataWidth-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              advance,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lbs_pkg::LevelWidth-1:0]    green_out,
    output logic [lbs_pkg::LevelWidth-1:0]    red_out,
    output logic [lbs_pkg::LevelWidth-1:0]    blue_out,
    output logic [lbs_pkg::PhaseWidth-1:0]    phase_out
);

    typedef struct packed {
        lbs_pkg::peaks_t               color;
        logic [lbs_pkg::PhaseWidth-1:0] phase_code;
    } result_t;

    lbs_pkg::peaks_t       peaks;
    lbs_pkg::step_result_t step_result;
    lbs_pkg::peaks_t       scaled;
    result_t               new_result;

    logic    accept;
    logic    take;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign take     = out_valid_reg && !out_stall;

    lbs_sequencer u_sequencer (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step_accept (accept),
        .advance     (advance),
        .peaks       (peaks),
        .step_result (step_result)
    );

    lbs_scaler u_scaler (
        .level  (step_result.level),
        .peaks  (peaks),
        .scaled (scaled)
    );

    assign new_result.color      = scaled;
    assign new_result.phase_code = step_result.phase_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (accept)
                out_data_reg <= new_result;
        end
        else if (accept)
        begin
            skid_data_reg <= new_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign green_out = out_data_reg.color.green;
    assign red_out   = out_data_reg.color.red;
    assign blue_out  = out_data_reg.color.blue;
    assign phase_out = out_data_reg.phase_code;

endmodule

// ----- dv/tb_led_breathing_sequencer.sv -----
module tb_led_breathing_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RequestTarget = 1850;
    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned HoldOffCycles = 96;

    typedef logic [lbs_pkg::LevelWidth-1:0] level_t;
    typedef logic [lbs_pkg::CfgIndexWidth-1:0] cfg_index_t;
    typedef logic [lbs_pkg::CfgDataWidth-1:0] cfg_data_t;

    typedef struct packed {
        logic [lbs_pkg::LevelWidth-1:0] green;
        logic [lbs_pkg::LevelWidth-1:0] red;
        logic [lbs_pkg::LevelWidth-1:0] blue;
        logic [lbs_pkg::PhaseWidth-1:0] phase;
    } color_t;

    class breath_tracker;
        logic [lbs_pkg::LevelWidth-1:0] green_peak;
        logic [lbs_pkg::LevelWidth-1:0] red_peak;
        logic [lbs_pkg::LevelWidth-1:0] blue_peak;
        logic [lbs_pkg::LevelWidth-1:0] hold_limit;
        logic [lbs_pkg::LevelWidth-1:0] level;
        logic [lbs_pkg::LevelWidth-1:0] hold_count;
        logic [lbs_pkg::PhaseWidth-1:0] phase;
        color_t colors_due[$];
        int unsigned errors;
        int unsigned matched;
        int unsigned ticks;
        int unsigned dark_entries;
        int unsigned early_wakes;
        int unsigned writes;

        function new();
            green_peak = '0;
            red_peak = '0;
            blue_peak = '0;
            hold_limit = lbs_pkg::HoldReset;
            level = lbs_pkg::LevelTop;
            hold_count = '0;
            phase = lbs_pkg::PhaseCodeFall;
        endfunction

        function void write_reg(cfg_index_t index, cfg_data_t data);
            writes++;
            if (index == lbs_pkg::RegHoldTicks && phase == lbs_pkg::PhaseCodeHold
                && hold_count >= data)
                early_wakes++;
            case (index)
                lbs_pkg::RegGreenLevel: green_peak = data;
                lbs_pkg::RegRedLevel:   red_peak = data;
                lbs_pkg::RegBlueLevel:  blue_peak = data;
                lbs_pkg::RegHoldTicks:  hold_limit = data;
                default: ;
            endcase
        endfunction

        function level_t scale(level_t peak);
            logic [2*lbs_pkg::LevelWidth-1:0] product;
            logic [2*lbs_pkg::LevelWidth-1:0] quotient;
            product = level * peak;
            quotient = product / lbs_pkg::LevelTop;
            return quotient[lbs_pkg::LevelWidth-1:0];
        endfunction

        function void take_request(logic adv);
            color_t c;
            if (adv)
            begin
                ticks++;
                case (phase)
                    lbs_pkg::PhaseCodeFall:
                    begin
                        if (level != '0)
                            level = level - 1'b1;
                        else
                        begin
                            phase = lbs_pkg::PhaseCodeHold;
                            dark_entries++;
                        end
                    end
                    lbs_pkg::PhaseCodeHold:
                    begin
                        if (hold_count < hold_limit)
                            hold_count = hold_count + 1'b1;
                        else
                        begin
                            phase = lbs_pkg::PhaseCodeRise;
                            hold_count = '0;
                        end
                    end
                    default:
                    begin
                        if (level != lbs_pkg::LevelTop)
                            level = level + 1'b1;
                        else
                            phase = lbs_pkg::PhaseCodeFall;
                    end
                endcase
            end
            c.green = scale(green_peak);
            c.red = scale(red_peak);
            c.blue = scale(blue_peak);
            c.phase = phase;
            colors_due.push_back(c);
        endfunction

        task flag_error(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_color(color_t got);
            color_t want;
            if (colors_due.size() == 0)
            begin
                flag_error($sformatf("unexpected result g=%0d r=%0d b=%0d phase=%0d",
                                     got.green, got.red, got.blue, got.phase));
                return;
            end
            want = colors_due.pop_front();
            if (got.green !== want.green)
                flag_error($sformatf("green_out %0d, want %0d", got.green, want.green));
            if (got.red !== want.red)
                flag_error($sformatf("red_out %0d, want %0d", got.red, want.red));
            if (got.blue !== want.blue)
                flag_error($sformatf("blue_out %0d, want %0d", got.blue, want.blue));
            if (got.phase !== want.phase)
                flag_error($sformatf("phase_out %0d, want %0d", got.phase, want.phase));
            matched++;
        endtask

        task close_out();
            if (colors_due.size() != 0)
                flag_error($sformatf("%0d results never arrived", colors_due.size()));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [lbs_pkg::CfgIndexWidth-1:0] cfg_index = '0;
    logic [lbs_pkg::CfgDataWidth-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic advance = 1'b0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    logic [lbs_pkg::LevelWidth-1:0] green_out;
    logic [lbs_pkg::LevelWidth-1:0] red_out;
    logic [lbs_pkg::LevelWidth-1:0] blue_out;
    logic [lbs_pkg::PhaseWidth-1:0] phase_out;

    breath_tracker tracker = new();
    int unsigned cycle_count = 0;
    int unsigned requests_sent = 0;
    int unsigned hold_off_asked = 0;
    int unsigned hold_off_done = 0;

    led_breathing_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .green_out (green_out),
        .red_out   (red_out),
        .blue_out  (blue_out),
        .phase_out (phase_out)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CycleLimit);
        $display("TEST FAILED");
        $finish;
    end

    // outputs and out_stall hold steady from one rising edge to the next
    always @(negedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
            tracker.check_color({green_out, red_out, blue_out, phase_out});
    end

    initial
    begin
        int unsigned mode;
        int unsigned span;
        int unsigned stall_pct;
        forever
        begin
            if (hold_off_asked != hold_off_done)
            begin
                hold_off_done = hold_off_asked;
                @(posedge clk);
                out_stall <= 1'b1;
                repeat (HoldOffCycles) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(4, 40);
                stall_pct = (mode == 0) ? 0 : (mode == 1) ? 25 : (mode == 2) ? 60 : 90;
                for (int i = 0; i < span && hold_off_asked == hold_off_done; i++)
                begin
                    @(posedge clk);
                    out_stall <= ($urandom_range(1, 100) <= stall_pct);
                end
            end
        end
    end

    function automatic level_t pick_level();
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, 1) ? lbs_pkg::LevelTop : '0;
        return level_t'($urandom_range(0, 255));
    endfunction

    task automatic offer(input logic adv);
        in_valid <= 1'b1;
        advance <= adv;
        @(negedge clk);
        while (in_stall !== 1'b0) @(negedge clk);
        @(posedge clk);
        tracker.take_request(adv);
        requests_sent++;
    endtask

    task automatic pause_sender(input int unsigned cycles);
        in_valid <= 1'b0;
        advance <= 1'($urandom_range(0, 1));
        repeat (cycles) @(posedge clk);
    endtask

    task automatic run_requests(input int unsigned count, input int unsigned advance_pct,
                                input bit no_gaps);
        int unsigned burst;
        int unsigned k;
        k = 0;
        while (k < count)
        begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && k < count; j++)
            begin
                offer($urandom_range(1, 100) <= advance_pct);
                k++;
            end
            if (!no_gaps && $urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 7));
        end
    endtask

    // hold the sender until every result is back
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.colors_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t index, input cfg_data_t data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        tracker.write_reg(index, data);
    endtask

    task automatic configure(input level_t green, input level_t red,
                             input level_t blue, input level_t hold,
                             input bit stray);
        write_reg(lbs_pkg::RegGreenLevel, green);
        write_reg(lbs_pkg::RegRedLevel, red);
        write_reg(lbs_pkg::RegBlueLevel, blue);
        write_reg(lbs_pkg::RegHoldTicks, hold);
        if (stray)
            write_reg(cfg_index_t'($urandom_range(4, 7)), cfg_data_t'($urandom_range(0, 255)));
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(1'b0);
        offer(1'b1);
        offer(1'b0);
        settle();
        configure(8'd255, 8'd1, 8'd128, 8'd0, 1'b1);
        offer(1'b0);
        offer(1'b1);
        offer(1'b1);
        offer(1'b0);
        pause_sender(3);
        offer(1'b1);
        settle();
        configure(8'd0, 8'd255, 8'd254, 8'd255, 1'b1);
        repeat (4) offer(1'b1);
        offer(1'b0);
        settle();
        configure(8'd255, 8'd255, 8'd255, 8'd200, 1'b1);
        repeat (6) offer(1'b1);
        settle();

        // drop the hold limit to at most the count while dark
        while (!(tracker.phase == lbs_pkg::PhaseCodeHold && tracker.hold_count >= 8))
            run_requests(8, 100, 1'b0);
        settle();
        write_reg(lbs_pkg::RegHoldTicks, cfg_data_t'($urandom_range(0, tracker.hold_count)));
        cfg_write <= 1'b0;
        @(posedge clk);
        run_requests(20, 100, 1'b0);
        settle();

        for (int p = 0; requests_sent < RequestTarget; p++)
        begin
            if (p == 0)
                configure(8'd255, 8'd255, 8'd255, 8'd0, 1'b1);
            else if (p == 1)
                configure(pick_level(), pick_level(), pick_level(), 8'd255, 1'b0);
            else
                configure(pick_level(), pick_level(), pick_level(), pick_level(),
                          $urandom_range(0, 1));
            if (p == 2)
            begin
                hold_off_asked++;
                run_requests(220, 90, 1'b1);
            end
            else
                run_requests($urandom_range(80, 200), (p % 5 == 4) ? 50 : 92, 1'b0);
            settle();
        end

        tracker.close_out();
        $display("Run covered %0d requests (%0d ticks), %0d results checked, %0d register writes.",
                 requests_sent, tracker.ticks, tracker.matched, tracker.writes);
        $display("Dark phase entered %0d times, hold cut short %0d times, %0d long receiver holds.",
                 tracker.dark_entries, tracker.early_wakes, hold_off_done);
        if (tracker.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
